/* src/erv_pkg.sv */
package erv_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ATAN_LEN         = 30;
  localparam int UNIT_Q           = 30;
  localparam int MERGE_LAT        = 6;

  // angle in degrees scaled by 10^9; 360e9 needs 39 bits, sign and headroom on top
  localparam int ZW = 41;
  // CORDIC x/y, 30 fraction bits plus growth
  localparam int XW = 34;

  localparam logic [ZW-1:0]        DEG_SCALE  = ZW'(64'd1000000000);
  localparam logic signed [ZW-1:0] FULL_DEG   = ZW'(64'sd360000000000);
  localparam logic signed [ZW-1:0] HALF_DEG   = ZW'(64'sd180000000000);
  localparam logic signed [ZW-1:0] QUART_DEG  = ZW'(64'sd90000000000);
  localparam logic [31:0]          RECIP_360  = 32'd11930465;  // ceil(2^32 / 360)
  localparam logic signed [XW-1:0] CORDIC_X0  = XW'(64'sd652032874);
  localparam logic signed [31:0]   UNIT_ONE   = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sincos_t;

  function automatic int cordic_ns(input int steps);
    return (steps < ATAN_LEN) ? steps : ATAN_LEN;
  endfunction

  // wrap (4 stages) + CORDIC steps + final clamp
  function automatic int lane_lat(input int steps);
    return cordic_ns(steps) + 5;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(UNIT_ONE)) r = UNIT_ONE;
    else if (v < -64'(UNIT_ONE)) r = -UNIT_ONE;
    else r = v[31:0];
    return r;
  endfunction

  // round(atan(2^-i) in degrees * 10^9)
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [63:0] v;
    case (idx)
      5'd0:  v = 64'sd45000000000;
      5'd1:  v = 64'sd26565051177;
      5'd2:  v = 64'sd14036243468;
      5'd3:  v = 64'sd7125016349;
      5'd4:  v = 64'sd3576334375;
      5'd5:  v = 64'sd1789910608;
      5'd6:  v = 64'sd895173710;
      5'd7:  v = 64'sd447614171;
      5'd8:  v = 64'sd223810500;
      5'd9:  v = 64'sd111905677;
      5'd10: v = 64'sd55952892;
      5'd11: v = 64'sd27976453;
      5'd12: v = 64'sd13988227;
      5'd13: v = 64'sd6994114;
      5'd14: v = 64'sd3497057;
      5'd15: v = 64'sd1748528;
      5'd16: v = 64'sd874264;
      5'd17: v = 64'sd437132;
      5'd18: v = 64'sd218566;
      5'd19: v = 64'sd109283;
      5'd20: v = 64'sd54642;
      5'd21: v = 64'sd27321;
      5'd22: v = 64'sd13660;
      5'd23: v = 64'sd6830;
      5'd24: v = 64'sd3415;
      5'd25: v = 64'sd1708;
      5'd26: v = 64'sd854;
      5'd27: v = 64'sd427;
      5'd28: v = 64'sd213;
      5'd29: v = 64'sd107;
      default: v = 64'sd0;
    endcase
    return v[ZW-1:0];
  endfunction

endpackage

/* src/euler_rotate_vector_top.sv */
// Euler-angle vector rotation. Each transfer in carries roll, pitch and yaw in
// degrees and a direction vector, all signed fixed point with FRAC_BITS
// fraction bits; each gives exactly one transfer out with the vector rotated by
// the matrix built from the three angles, saturated to 32 bits, with a flag
// when any component was clipped. The datapath is a single pipeline that takes
// one item every clock unless a stalled result holds it: three identical angle
// lanes (mod-360 wrap in four stages, then one CORDIC step per stage, then a
// clamp) run side by side and a six-stage merge builds the matrix and the
// product. The whole pipeline advances whenever the output register is empty
// or being taken, so in_ready follows out_ready combinationally and a stalled
// result holds everything behind it. No state beyond the pipeline; reset only
// clears the valid bits.
module euler_rotate_vector_top #(
  parameter int FRAC_BITS    = erv_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = erv_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  erv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output erv_pkg::out_t out_data
);
  import erv_pkg::*;

  localparam int LANE_LAT = lane_lat(CORDIC_STEPS);
  localparam int LAT      = LANE_LAT + MERGE_LAT;

  logic           advance;
  logic [LAT-1:0] vld;

  // pipeline moves when the last stage is free or its transfer completes
  assign advance   = !vld[LAT-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  sincos_t sc_roll, sc_pitch, sc_yaw;

  erv_lane #(.FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(advance), .angle(in_data.roll_deg), .sc(sc_roll)
  );
  erv_lane #(.FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(advance), .angle(in_data.pitch_deg), .sc(sc_pitch)
  );
  erv_lane #(.FRAC_BITS(FRAC_BITS), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(advance), .angle(in_data.yaw_deg), .sc(sc_yaw)
  );

  // merge delays the vector by the lane latency so it meets its angles
  erv_merge #(.LEAD(LANE_LAT)) u_merge (
    .clk(clk),
    .en(advance),
    .roll(sc_roll),
    .pitch(sc_pitch),
    .yaw(sc_yaw),
    .fwd_x(in_data.fwd_x),
    .fwd_y(in_data.fwd_y),
    .fwd_z(in_data.fwd_z),
    .res(out_data)
  );

endmodule

/* src/erv_lane.sv */
module erv_lane #(
  parameter int FRAC_BITS = erv_pkg::FRAC_BITS_DEF,
  parameter int STEPS     = erv_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  angle,
  output erv_pkg::sincos_t    sc
);
  import erv_pkg::*;

  localparam int AW = 32 - FRAC_BITS;
  localparam int NS = cordic_ns(STEPS);

  // stage 0: whole degrees times 1/360
  logic signed [AW-1:0]   a0;
  logic [FRAC_BITS-1:0]   rl0;
  logic signed [AW+32:0]  prod0;

  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= angle[31:FRAC_BITS];
      rl0   <= angle[FRAC_BITS-1:0];
      prod0 <= $signed(angle[31:FRAC_BITS]) * $signed({1'b0, RECIP_360});
    end
  end

  // stage 1: whole degrees mod 360, estimate off by at most one
  logic signed [AW:0]   q0;
  logic signed [47:0]   rh0;
  logic signed [47:0]   rh0c;
  logic [8:0]           rh1;
  logic [FRAC_BITS-1:0] rl1;

  always_comb begin
    q0  = prod0[AW+32:32];
    rh0 = 48'(a0) - 48'(q0) * 48'sd360;
    if (rh0 < 0) rh0c = rh0 + 48'sd360;
    else if (rh0 >= 48'sd360) rh0c = rh0 - 48'sd360;
    else rh0c = rh0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rh1 <= rh0c[8:0];
      rl1 <= rl0;
    end
  end

  // stage 2: degrees * 10^9
  logic [FRAC_BITS+29:0] zl_prod;
  logic [ZW-1:0]         zh;
  logic signed [ZW-1:0]  z2;

  always_comb begin
    zl_prod = (FRAC_BITS+30)'(rl1) * (FRAC_BITS+30)'(DEG_SCALE);
    zh      = ZW'(rh1) * DEG_SCALE;
  end

  always_ff @(posedge clk) begin
    if (en) z2 <= $signed(zh + ZW'(zl_prod >> FRAC_BITS));
  end

  // stage 3: fold into [-90, 90]
  logic signed [ZW-1:0] zw, zf;
  logic                 flip_c;
  logic signed [ZW-1:0] z3;
  logic                 flip3;

  always_comb begin
    zw     = (z2 > HALF_DEG) ? z2 - FULL_DEG : z2;
    flip_c = 1'b0;
    zf     = zw;
    if (zw > QUART_DEG) begin
      zf     = zw - HALF_DEG;
      flip_c = 1'b1;
    end else if (zw < -QUART_DEG) begin
      zf     = zw + HALF_DEG;
      flip_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z3    <= zf;
      flip3 <= flip_c;
    end
  end

  // CORDIC, one step per stage
  logic signed [XW-1:0] cx [0:NS];
  logic signed [XW-1:0] cy [0:NS];
  logic signed [ZW-1:0] cz [0:NS];
  logic                 fl [0:NS];

  assign cx[0] = CORDIC_X0;
  assign cy[0] = '0;
  assign cz[0] = z3;
  assign fl[0] = flip3;

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_deg(5'(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_deg(5'(i));
        end
      end
    end
  end

  logic signed [XW-1:0] xo, yo;

  always_comb begin
    xo = fl[NS] ? -cx[NS] : cx[NS];
    yo = fl[NS] ? -cy[NS] : cy[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc.c <= clamp_unit(64'(xo));
      sc.s <= clamp_unit(64'(yo));
    end
  end

endmodule

/* src/erv_merge.sv */
module erv_merge #(
  parameter int LEAD = 25
) (
  input  logic               clk,
  input  logic               en,
  input  erv_pkg::sincos_t   roll,
  input  erv_pkg::sincos_t   pitch,
  input  erv_pkg::sincos_t   yaw,
  input  logic signed [31:0] fwd_x,
  input  logic signed [31:0] fwd_y,
  input  logic signed [31:0] fwd_z,
  output erv_pkg::out_t      res
);
  import erv_pkg::*;

  function automatic logic signed [31:0] qfin(input logic signed [63:0] p);
    return clamp_unit(p >>> UNIT_Q);
  endfunction

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // vector waits while the lanes work
  vec_t fd [0:LEAD];
  assign fd[0] = '{x: fwd_x, y: fwd_y, z: fwd_z};
  for (genvar i = 0; i < LEAD; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) fd[i+1] <= fd[i];
    end
  end

  // P1: first-level products
  logic signed [63:0] p_srsp, p_crsp, p_cpcy, p_cpsy, p_srcp, p_crcp;
  logic signed [63:0] p_crsy, p_crcy, p_srsy, p_srcy;
  logic signed [31:0] sp1, sy1, cy1;
  vec_t               f1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_srsp <= roll.s * pitch.s;
      p_crsp <= roll.c * pitch.s;
      p_cpcy <= pitch.c * yaw.c;
      p_cpsy <= pitch.c * yaw.s;
      p_srcp <= roll.s * pitch.c;
      p_crcp <= roll.c * pitch.c;
      p_crsy <= roll.c * yaw.s;
      p_crcy <= roll.c * yaw.c;
      p_srsy <= roll.s * yaw.s;
      p_srcy <= roll.s * yaw.c;
      sp1    <= pitch.s;
      sy1    <= yaw.s;
      cy1    <= yaw.c;
      f1     <= fd[LEAD];
    end
  end

  // P2: scale and clamp
  logic signed [31:0] srsp2, crsp2, m0_2, m1_2, m2_2, m5_2, m8_2;
  logic signed [31:0] crsy2, crcy2, srsy2, srcy2, sy2, cy2;
  vec_t               f2;

  always_ff @(posedge clk) begin
    if (en) begin
      srsp2 <= qfin(p_srsp);
      crsp2 <= qfin(p_crsp);
      m0_2  <= qfin(p_cpcy);
      m1_2  <= qfin(p_cpsy);
      m2_2  <= clamp_unit(-64'(sp1));
      m5_2  <= qfin(p_srcp);
      m8_2  <= qfin(p_crcp);
      crsy2 <= qfin(p_crsy);
      crcy2 <= qfin(p_crcy);
      srsy2 <= qfin(p_srsy);
      srcy2 <= qfin(p_srcy);
      sy2   <= sy1;
      cy2   <= cy1;
      f2    <= f1;
    end
  end

  // P3: second-level products
  logic signed [63:0] p_a, p_b, p_c, p_d;
  logic signed [31:0] m0_3, m1_3, m2_3, m5_3, m8_3, crsy3, crcy3, srsy3, srcy3;
  vec_t               f3;

  always_ff @(posedge clk) begin
    if (en) begin
      p_a   <= srsp2 * cy2;
      p_b   <= srsp2 * sy2;
      p_c   <= crsp2 * cy2;
      p_d   <= crsp2 * sy2;
      m0_3  <= m0_2;
      m1_3  <= m1_2;
      m2_3  <= m2_2;
      m5_3  <= m5_2;
      m8_3  <= m8_2;
      crsy3 <= crsy2;
      crcy3 <= crcy2;
      srsy3 <= srsy2;
      srcy3 <= srcy2;
      f3    <= f2;
    end
  end

  // P4: remaining matrix entries
  logic signed [31:0] m [0:8];
  vec_t               f4;

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= m0_3;
      m[1] <= m1_3;
      m[2] <= m2_3;
      m[3] <= clamp_unit(64'(qfin(p_a)) - 64'(crsy3));
      m[4] <= clamp_unit(64'(qfin(p_b)) + 64'(crcy3));
      m[5] <= m5_3;
      m[6] <= clamp_unit(64'(qfin(p_c)) + 64'(srsy3));
      m[7] <= clamp_unit(64'(qfin(p_d)) - 64'(srcy3));
      m[8] <= m8_3;
      f4   <= f3;
    end
  end

  // P5: vector times matrix, column by column
  logic signed [63:0] pv [0:8];

  for (genvar j = 0; j < 3; j++) begin : g_col
    always_ff @(posedge clk) begin
      if (en) begin
        pv[3*j]   <= f4.x * m[j];
        pv[3*j+1] <= f4.y * m[j+3];
        pv[3*j+2] <= f4.z * m[j+6];
      end
    end
  end

  // P6: sum, round half up, saturate
  logic signed [63:0] sum [0:2];
  logic signed [63:0] sh  [0:2];
  logic signed [31:0] dv  [0:2];
  logic [2:0]         clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = pv[3*k] + pv[3*k+1] + pv[3*k+2] + (64'sd1 <<< (UNIT_Q - 1));
      sh[k]  = sum[k] >>> UNIT_Q;
      if (sh[k] > 64'sd2147483647) begin
        dv[k]   = 32'sh7fffffff;
        clip[k] = 1'b1;
      end else if (sh[k] < -64'sd2147483648) begin
        dv[k]   = 32'sh80000000;
        clip[k] = 1'b1;
      end else begin
        dv[k]   = sh[k][31:0];
        clip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.dir_x     <= dv[0];
      res.dir_y     <= dv[1];
      res.dir_z     <= dv[2];
      res.saturated <= |clip;
    end
  end

endmodule

/* src/erv_checker.sv */
module erv_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input erv_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input erv_pkg::out_t out_data
);
  import erv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.dir_x == 32'sh7fffffff || out_data.dir_x == 32'sh80000000 ||
      out_data.dir_y == 32'sh7fffffff || out_data.dir_y == 32'sh80000000 ||
      out_data.dir_z == 32'sh7fffffff || out_data.dir_z == 32'sh80000000)
    else $error("saturated flag without clipped component");

endmodule

bind euler_rotate_vector_top erv_checker u_erv_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Bench for the Euler-angle vector rotation pipeline.
// Stimulus is a short directed table, then random items; each accepted input
// transfer is run through a bit-true model of the datapath below, or takes a
// hand-typed result, and the prediction is queued; each output transfer is
// checked against the oldest one. Idling on both channels runs in four phases.
module testbench;
  import erv_pkg::*;

  localparam int    STEPS      = CORDIC_STEPS_DEF;
  localparam int    FBITS      = FRAC_BITS_DEF;
  localparam int    N_RANDOM   = 1500;
  localparam int    STALL_MAX  = 20000;   // cycles without any transfer
  localparam longint ONE_Q30   = 64'sd1 << 30;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  euler_rotate_vector_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idling percentages, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  out_t   rotated_q[$];
  int     mismatches = 0;
  int     stall_cycles = 0;

  // arctangent of 2^-i in degrees * 10^9
  longint atan_tab[30] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375, 64'sd1789910608, 64'sd895173710, 64'sd447614171,
    64'sd223810500, 64'sd111905677, 64'sd55952892, 64'sd27976453,
    64'sd13988227, 64'sd6994114, 64'sd3497057, 64'sd1748528,
    64'sd874264, 64'sd437132, 64'sd218566, 64'sd109283,
    64'sd54642, 64'sd27321, 64'sd13660, 64'sd6830,
    64'sd3415, 64'sd1708, 64'sd854, 64'sd427,
    64'sd213, 64'sd107
  };

  // >>> on signed longint is an arithmetic (floor) shift
  function automatic longint clip_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return clip_unit((a * b) >>> 30);
  endfunction

  // wrap, fold into +-90 degrees, CORDIC, unfold
  function automatic void angle_trig(logic signed [31:0] ang,
                                     output longint s, output longint c);
    longint full, r, z, x, y, dx, dy;
    bit     flip;
    full = 360 * (64'sd1 << FBITS);
    r = longint'(ang) % full;
    flip = 0;
    if (r < 0) r += full;
    z = (r * 1000000000) >>> FBITS;
    if (z > 64'sd180000000000) z -= 64'sd360000000000;
    if (z > 64'sd90000000000) begin
      z -= 64'sd180000000000;
      flip = 1;
    end else if (z < -64'sd90000000000) begin
      z += 64'sd180000000000;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip_unit(x);
    s = clip_unit(y);
  endfunction

  function automatic logic signed [31:0] dot_round(longint a, longint b, longint c,
                                                   longint ma, longint mb, longint mc,
                                                   inout bit clipped);
    longint v;
    v = (a * ma + b * mb + c * mc + (64'sd1 << 29)) >>> 30;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647; clipped = 1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648; clipped = 1;
    end
    return v[31:0];
  endfunction

  function automatic out_t rotate_vector(in_t d);
    longint sr, cr, sp, cp, sy, cy, srsp, crsp, fx, fy, fz;
    longint m[9];
    bit     clipped;
    out_t   o;
    clipped = 0;
    angle_trig(d.roll_deg, sr, cr);
    angle_trig(d.pitch_deg, sp, cp);
    angle_trig(d.yaw_deg, sy, cy);
    fx = d.fwd_x; fy = d.fwd_y; fz = d.fwd_z;
    srsp = fmul(sr, sp);
    crsp = fmul(cr, sp);
    m[0] = fmul(cp, cy);
    m[1] = fmul(cp, sy);
    m[2] = clip_unit(-sp);
    m[3] = clip_unit(fmul(srsp, cy) - fmul(cr, sy));
    m[4] = clip_unit(fmul(srsp, sy) + fmul(cr, cy));
    m[5] = fmul(sr, cp);
    m[6] = clip_unit(fmul(crsp, cy) + fmul(sr, sy));
    m[7] = clip_unit(fmul(crsp, sy) - fmul(sr, cy));
    m[8] = fmul(cr, cp);
    o.dir_x = dot_round(fx, fy, fz, m[0], m[3], m[6], clipped);
    o.dir_y = dot_round(fx, fy, fz, m[1], m[4], m[7], clipped);
    o.dir_z = dot_round(fx, fy, fz, m[2], m[5], m[8], clipped);
    o.saturated = clipped;
    return o;
  endfunction

  // Directed table. has_exp marks rows whose result is typed in by hand.
  typedef struct {
    in_t  stim;
    bit   has_exp;
    out_t exp;
  } dir_row_t;

  localparam logic signed [31:0] DEG1 = 32'sd65536;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  dir_row_t dir_tab[$];

  function automatic in_t mk(logic signed [31:0] r, logic signed [31:0] p,
                             logic signed [31:0] y, logic signed [31:0] x,
                             logic signed [31:0] vy, logic signed [31:0] vz);
    in_t d;
    d.roll_deg = r; d.pitch_deg = p; d.yaw_deg = y;
    d.fwd_x = x; d.fwd_y = vy; d.fwd_z = vz;
    return d;
  endfunction

  task automatic add_row(in_t d, bit he = 0, out_t e = '0);
    dir_row_t row;
    row.stim = d; row.has_exp = he; row.exp = e;
    dir_tab.push_back(row);
  endtask

  task automatic build_table();
    // zero vector is zero whatever the angles
    add_row(mk(0, 0, 0, 0, 0, 0), 1, '0);
    add_row(mk(MAXV, MINV, MAXV, 0, 0, 0), 1, '0);
    add_row(mk(0, 0, 0, DEG1, 2 * DEG1, -3 * DEG1));
    add_row(mk(90 * DEG1, 0, 0, 0, DEG1, 0));
    add_row(mk(0, 90 * DEG1, 0, DEG1, 0, 0));
    add_row(mk(0, 0, 90 * DEG1, DEG1, 0, 0));
    add_row(mk(-90 * DEG1, -90 * DEG1, -90 * DEG1, DEG1, DEG1, DEG1));
    // wrap: exactly 180 and just beyond, and whole turns
    add_row(mk(180 * DEG1, 180 * DEG1 + 1, -180 * DEG1, DEG1, DEG1, DEG1));
    add_row(mk(90 * DEG1 + 1, -90 * DEG1 - 1, 270 * DEG1, DEG1, -DEG1, DEG1));
    add_row(mk(360 * DEG1, -360 * DEG1, 720 * DEG1 + 5, DEG1, DEG1, DEG1));
    add_row(mk(MAXV, MINV, 1, MAXV, MINV, MAXV));
    add_row(mk(-1, 1, MINV, MINV, MAXV, MINV));
    // overflow: rotating a full-scale vector by 45 degrees clips
    add_row(mk(0, 0, 45 * DEG1, MAXV, MAXV, 0));
    add_row(mk(45 * DEG1, 45 * DEG1, 45 * DEG1, MINV, MINV, MINV));
    add_row(mk(0, 0, 0, MAXV, MINV, MAXV));
    add_row(mk(30 * DEG1, 60 * DEG1, 120 * DEG1, 32'sh12345678, -32'sh0abcdef0, 77));
    add_row(mk(-45 * DEG1, 135 * DEG1, -135 * DEG1, 1, -1, 1));
  endtask

  function automatic logic [31:0] rnd_field(bit is_angle);
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return $urandom_range(0, 3) - 1;
      3, 4: return is_angle ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return is_angle ? 32'($signed($urandom_range(0, 720 * 65536))
                                      - 360 * 65536)
                               : $urandom;
    endcase
  endfunction

  // Sender: one transfer per call, idle cycles before it at the phase's rate.
  // Valid stays high between back-to-back items; the caller drops it at the end.
  task automatic send_item(in_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Record predictions at the transfer edge; hand-typed rows override.
  bit   have_typed = 0;
  out_t typed_exp;
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) rotated_q.push_back(have_typed ? typed_exp
                                                                       : rotate_vector(in_data));
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transfer %h", out_data);
        end else begin
          out_t e;
          e = rotated_q.pop_front();
          if (out_data.dir_x !== e.dir_x || out_data.dir_y !== e.dir_y ||
              out_data.dir_z !== e.dir_z || out_data.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h z=%h sat=%b  got x=%h y=%h z=%h sat=%b",
                       e.dir_x, e.dir_y, e.dir_z, e.saturated, out_data.dir_x,
                       out_data.dir_y, out_data.dir_z, out_data.saturated);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no transfer either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else if (rotated_q.size() != 0 || in_valid) stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_t d;
    build_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    foreach (dir_tab[i]) begin
      have_typed <= dir_tab[i].has_exp;
      typed_exp  <= dir_tab[i].exp;
      send_item(dir_tab[i].stim);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    have_typed <= 1'b0;
    drain();   // sender holds off until every result is back

    // random part over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        d.roll_deg  = rnd_field(1);
        d.pitch_deg = rnd_field(1);
        d.yaw_deg   = rnd_field(1);
        d.fwd_x     = rnd_field(0);
        d.fwd_y     = rnd_field(0);
        d.fwd_z     = rnd_field(0);
        send_item(d);
      end
    end
    in_valid <= 1'b0;

    recv_stall_pct = 0;
    drain();
    repeat (cordic_ns(STEPS) + 20) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/erv_pkg.sv
src/erv_lane.sv
src/erv_merge.sv
src/euler_rotate_vector_top.sv
src/erv_checker.sv
bench/testbench.sv
